// ===== design/gta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_pkg
// shared types and constants of the greedy threshold assignment block
// ----------------------------------------------------------------------------
package gta_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    // index fields cover the whole parameter range (up to 64)
    localparam int IDX_W  = 6;
    localparam int COST_W = 16;
    localparam int THR_W  = 15;

    localparam logic [COST_W:0]  ONE_Q14    = 17'd16384;
    localparam logic [THR_W-1:0] THRESH_RST = 15'd8192;

    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_COL_COUNT    = 2'd1;
    localparam logic [1:0] REG_MATCH_THRESH = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    localparam logic [1:0] KIND_MATCH = 2'd0;
    localparam logic [1:0] KIND_ROW   = 2'd1;
    localparam logic [1:0] KIND_COL   = 2'd2;

    // best candidate travelling down the row chain
    typedef struct packed {
        logic              found;
        logic [COST_W-1:0] cost;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
    } t_cand;

    // broadcast from the sequencer to every row cell
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_row;
        logic [IDX_W-1:0]  wr_col;
        logic [COST_W-1:0] wr_data;
        logic              clr_taken;
        logic              take_en;
        logic [IDX_W-1:0]  take_row;
        logic              clr_best;
        logic              sw_vld;
        logic [IDX_W-1:0]  sw_col;
        logic              sw_free;
        logic [THR_W-1:0]  thresh;
        logic [IDX_W:0]    rows;
    } t_ctl;

endpackage

// ===== design/greedy_threshold_assignment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_threshold_assignment
// greedy row/column assignment over a gated cost matrix, on a chain of row cells
// ----------------------------------------------------------------------------
// usage
//   input stream: each word is a command in tuser (0 = write cost, 1 = solve);
//   a write stores one Q2.14 cost at (row, col)
//   a solve clears the taken flags and runs greedy passes; each pass sweeps
//   the active columns (one column per cycle into every row cell), then lets
//   the row minima settle through the chain of MAX_ROWS cells
//   a solve runs at most min(rows, cols) + 1 passes, then walks the rows and
//   the columns for the unmatched lists and flushes the held-back word
//   output stream: matches in the order taken, then unmatched rows, then
//   unmatched columns; tlast marks the final word of a solve
//   one result is held back so that tlast is known when it leaves
//   the input is taken only while no solve is running; an output stall
//   simply holds the sequencer until the output register frees up
//   reset clears the sequencer, the taken flags and the count registers,
//   and sets match_thresh to 8192; cost entries hold garbage until written
//   apb port: row_count at 0x0, col_count at 0x4, match_thresh at 0x8
// ----------------------------------------------------------------------------
module greedy_threshold_assignment #(
    parameter int MAX_ROWS = gta_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gta_pkg::MAX_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // row_index[4:0], col_index[9:5], cost_value[25:10]
    input  logic [0:0]  i_s_axis_tuser,   // opcode[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // out_row[4:0], out_col[9:5]
    output logic [1:0]  o_m_axis_tuser,   // result_kind[1:0]
    output logic        o_m_axis_tlast,   // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW   = gta_pkg::IDX_W;
    localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    // wait for the last compare to reach the end of the chain
    localparam int WAIT_N = MAX_ROWS + 2;
    localparam int WCW    = $clog2(WAIT_N + 1);
    localparam logic [IW:0] ROWS_MAX = (IW + 1)'(MAX_ROWS);
    localparam logic [IW:0] COLS_MAX = (IW + 1)'(MAX_COLS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_WAIT  = 6'b000100,
        S_ROWS  = 6'b001000,
        S_COLS  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] row;
        logic [4:0] col;
    } t_res;

    // configuration registers
    logic [5:0]                r_row_count;
    logic [5:0]                r_col_count;
    logic [gta_pkg::THR_W-1:0] r_thresh;
    logic                      cfg_wr;

    // sequencer
    t_state        r_state, n_state;
    logic [IW:0]   r_cnt, n_cnt;
    logic [WCW-1:0] r_wcnt, n_wcnt;
    logic [IW:0]   r_rows, n_rows;
    logic [IW:0]   r_cols, n_cols;
    logic [MAX_COLS-1:0] r_col_taken, n_col_taken;
    logic [IW:0]   rows_sat, cols_sat;

    // held-back result and output register
    logic  r_pend_vld, n_pend_vld;
    t_res  r_pend, n_pend;
    logic  r_out_vld;
    t_res  r_out;
    logic  r_out_last;
    logic  out_free, can_push, load_out, load_last;

    gta_pkg::t_ctl  ctl;
    gta_pkg::t_cand w_chain [MAX_ROWS+1];
    gta_pkg::t_cand winner;
    logic [MAX_ROWS-1:0] w_row_taken;
    logic           in_fire;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
            r_col_count <= '0;
            r_thresh    <= gta_pkg::THRESH_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                gta_pkg::REG_ROW_COUNT:    r_row_count <= pwdata[5:0];
                gta_pkg::REG_COL_COUNT:    r_col_count <= pwdata[5:0];
                gta_pkg::REG_MATCH_THRESH: r_thresh    <= pwdata[gta_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gta_pkg::REG_ROW_COUNT:    prdata = {26'd0, r_row_count};
            gta_pkg::REG_COL_COUNT:    prdata = {26'd0, r_col_count};
            gta_pkg::REG_MATCH_THRESH: prdata = {17'd0, r_thresh};
            default:                   prdata = 32'd0;
        endcase
    end

    // counts saturate at the matrix size
    assign rows_sat = ({1'b0, r_row_count} > ROWS_MAX) ? ROWS_MAX : {1'b0, r_row_count};
    assign cols_sat = ({1'b0, r_col_count} > COLS_MAX) ? COLS_MAX : {1'b0, r_col_count};

    // ---------------- row cell chain ----------------
    assign w_chain[0] = '0;

    for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
        gta_cell #(
            .MAX_COLS (MAX_COLS),
            .ROW_ID   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_taken (w_row_taken[g])
        );
    end

    assign winner = w_chain[MAX_ROWS];

    // ---------------- sequencer ----------------
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign can_push = !r_pend_vld || out_free;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_wcnt      = r_wcnt;
        n_rows      = r_rows;
        n_cols      = r_cols;
        n_col_taken = r_col_taken;
        n_pend_vld  = r_pend_vld;
        n_pend      = r_pend;
        load_out    = 1'b0;
        load_last   = 1'b0;

        ctl           = '0;
        ctl.wr_row    = {1'b0, i_s_axis_tdata[4:0]};
        ctl.wr_col    = {1'b0, i_s_axis_tdata[9:5]};
        ctl.wr_data   = i_s_axis_tdata[25:10];
        ctl.thresh    = r_thresh;
        ctl.rows      = r_rows;
        ctl.sw_col    = r_cnt[IW-1:0];
        ctl.take_row  = winner.row;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_s_axis_tuser[0] == gta_pkg::OP_WRITE) begin
                        ctl.wr_en = 1'b1;
                    end else begin
                        ctl.clr_taken = 1'b1;
                        n_col_taken   = '0;
                        n_rows        = rows_sat;
                        n_cols        = cols_sat;
                        n_cnt         = '0;
                        if (rows_sat == '0 || cols_sat == '0) begin
                            n_state = S_ROWS;
                        end else begin
                            ctl.clr_best = 1'b1;
                            n_state      = S_SWEEP;
                        end
                    end
                end
            end
            S_SWEEP: begin
                // one column per cycle into every row cell
                ctl.sw_vld  = 1'b1;
                ctl.sw_free = !r_col_taken[r_cnt[CIW-1:0]];
                if (r_cnt == r_cols - 1'b1) begin
                    n_wcnt  = '0;
                    n_state = S_WAIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WAIT: begin
                if (r_wcnt != WCW'(WAIT_N)) begin
                    n_wcnt = r_wcnt + 1'b1;
                end else if (winner.found) begin
                    if (can_push) begin
                        n_pend_vld   = 1'b1;
                        n_pend.kind  = gta_pkg::KIND_MATCH;
                        n_pend.row   = winner.row[4:0];
                        n_pend.col   = winner.col[4:0];
                        load_out     = r_pend_vld;
                        ctl.take_en  = 1'b1;
                        ctl.clr_best = 1'b1;
                        n_col_taken[winner.col[CIW-1:0]] = 1'b1;
                        n_cnt        = '0;
                        n_state      = S_SWEEP;
                    end
                end else begin
                    n_cnt   = '0;
                    n_state = S_ROWS;
                end
            end
            S_ROWS: begin
                if (r_cnt == r_rows) begin
                    n_cnt   = '0;
                    n_state = S_COLS;
                end else if (w_row_taken[r_cnt[RIW-1:0]]) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (can_push) begin
                    n_pend_vld  = 1'b1;
                    n_pend.kind = gta_pkg::KIND_ROW;
                    n_pend.row  = r_cnt[4:0];
                    n_pend.col  = 5'd0;
                    load_out    = r_pend_vld;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            S_COLS: begin
                if (r_cnt == r_cols) begin
                    n_state = S_FLUSH;
                end else if (r_col_taken[r_cnt[CIW-1:0]]) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (can_push) begin
                    n_pend_vld  = 1'b1;
                    n_pend.kind = gta_pkg::KIND_COL;
                    n_pend.row  = 5'd0;
                    n_pend.col  = r_cnt[4:0];
                    load_out    = r_pend_vld;
                    n_cnt       = r_cnt + 1'b1;
                end
            end
            S_FLUSH: begin
                // the held-back word is the last of the solve
                if (!r_pend_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    load_out   = 1'b1;
                    load_last  = 1'b1;
                    n_pend_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_wcnt      <= '0;
            r_rows      <= '0;
            r_cols      <= '0;
            r_col_taken <= '0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wcnt      <= n_wcnt;
            r_rows      <= n_rows;
            r_cols      <= n_cols;
            r_col_taken <= n_col_taken;
            r_pend_vld  <= n_pend_vld;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (load_out) begin
            r_out      <= r_pend;
            r_out_last <= load_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out.col, r_out.row};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== design/gta_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_cell
// one matrix row: cost memory, row-taken flag, row minimum and chain stage
// ----------------------------------------------------------------------------
module gta_cell #(
    parameter int MAX_COLS = gta_pkg::MAX_COLS_DEF,
    parameter int ROW_ID   = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gta_pkg::t_ctl i_ctl,
    input  gta_pkg::t_cand i_chain,
    output gta_pkg::t_cand o_chain,
    output logic          o_taken
);

    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [gta_pkg::IDX_W:0] ROW_K = (gta_pkg::IDX_W + 1)'(ROW_ID);
    localparam logic [gta_pkg::IDX_W:0] COL_N = (gta_pkg::IDX_W + 1)'(MAX_COLS);

    logic [gta_pkg::COST_W-1:0] r_mem [MAX_COLS];
    logic [gta_pkg::COST_W-1:0] r_rd;
    logic                       r_sw_vld;
    logic                       r_sw_free;
    logic [gta_pkg::IDX_W-1:0]  r_sw_col;
    logic                       r_taken;
    gta_pkg::t_cand             r_best;
    gta_pkg::t_cand             r_chain;

    logic                       wr_ok;
    logic                       active;
    logic [gta_pkg::COST_W:0]   sum;
    logic                       better;
    logic                       in_win;

    assign wr_ok = i_ctl.wr_en && ({1'b0, i_ctl.wr_row} == ROW_K)
                   && ({1'b0, i_ctl.wr_col} < COL_N);
    assign active = ROW_K < i_ctl.rows;
    assign sum    = {1'b0, r_rd} + {2'b00, i_ctl.thresh};
    assign better = r_sw_vld && r_sw_free && active && !r_taken
                    && (sum <= gta_pkg::ONE_Q14)
                    && (!r_best.found || (r_rd < r_best.cost));
    // ties keep the earlier row coming down the chain
    assign in_win = i_chain.found && (!r_best.found || (i_chain.cost <= r_best.cost));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[i_ctl.wr_col[CIW-1:0]] <= i_ctl.wr_data;
        end
        if (i_ctl.sw_vld) begin
            r_rd <= r_mem[i_ctl.sw_col[CIW-1:0]];
        end
        r_sw_col  <= i_ctl.sw_col;
        r_sw_free <= i_ctl.sw_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_vld      <= 1'b0;
            r_taken       <= 1'b0;
            r_best.found  <= 1'b0;
            r_chain.found <= 1'b0;
        end else begin
            r_sw_vld <= i_ctl.sw_vld;
            if (i_ctl.clr_taken) begin
                r_taken <= 1'b0;
            end else if (i_ctl.take_en && ({1'b0, i_ctl.take_row} == ROW_K)) begin
                r_taken <= 1'b1;
            end
            if (i_ctl.clr_best) begin
                r_best.found <= 1'b0;
            end else if (better) begin
                r_best.found <= 1'b1;
                r_best.cost  <= r_rd;
                r_best.row   <= ROW_K[gta_pkg::IDX_W-1:0];
                r_best.col   <= r_sw_col;
            end
            r_chain <= in_win ? i_chain : r_best;
        end
    end

    assign o_chain = r_chain;
    assign o_taken = r_taken;

endmodule

// ===== design/gta_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gta_chk
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module gta_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
        && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result word changed under stall");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == gta_pkg::KIND_MATCH
        || o_m_axis_tuser == gta_pkg::KIND_ROW || o_m_axis_tuser == gta_pkg::KIND_COL))
        else $error("bad result kind");

    a_row_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == gta_pkg::KIND_ROW |-> o_m_axis_tdata[9:5] == 5'd0)
        else $error("unmatched row carries a column");

    a_col_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == gta_pkg::KIND_COL |-> o_m_axis_tdata[4:0] == 5'd0)
        else $error("unmatched column carries a row");

endmodule

bind greedy_threshold_assignment gta_chk u_gta_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
